// ----- rtl/core/iuhp_pkg.sv -----
// shared types and constants for the ipv4/udp header parser
// no dependencies
package iuhp_pkg;

    localparam int unsigned CHAIN_DEPTH = 15;

    localparam logic [4:0]  POS_IDLE     = 5'd28;
    localparam logic [4:0]  POS_VERSION  = 5'd0;
    localparam logic [4:0]  POS_PROTOCOL = 5'd9;
    localparam logic [4:0]  POS_HDR_LAST = 5'd19;
    localparam logic [4:0]  POS_UDP_LAST = 5'd27;
    localparam logic [4:0]  HDR_BYTES    = 5'd20;

    localparam logic [3:0]  IPV4_VERSION = 4'd4;
    localparam logic [7:0]  UDP_PROTOCOL = 8'h11;
    localparam logic [15:0] SUM_GOOD     = 16'hffff;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CSUM = 2'd1,
        ST_NOT_IPV4 = 2'd2,
        ST_NOT_UDP  = 2'd3
    } status_t;

    typedef struct packed {
        logic clear;
        logic add;
    } csum_ctrl_t;

endpackage

// ----- rtl/core/iuhp_byte_cell.sv -----
// one byte cell of the header capture chain
// depends on nothing; instantiated by ipv4_udp_header_parser
module iuhp_byte_cell (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] d_out
);

    logic [7:0] data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;

endmodule

// ----- rtl/core/iuhp_csum.sv -----
// ones' complement header sum with end-around carry
// depends on iuhp_pkg
module iuhp_csum (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iuhp_pkg::csum_ctrl_t ctrl,
    input  logic [15:0]          word,
    output logic [15:0]          sum_next
);
    import iuhp_pkg::*;

    logic [15:0] sum_reg;
    logic [16:0] raw_sum;

    assign raw_sum  = {1'b0, sum_reg} + {1'b0, word};
    assign sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.clear) begin
            sum_reg <= '0;
        end else if (ctrl.add) begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ----- rtl/core/ipv4_udp_header_parser.sv -----
// top level of the ipv4/udp header parser: position control, result register
// depends on iuhp_pkg, iuhp_byte_cell, iuhp_csum
//
// usage
//   s_ channel: one packet byte per item in s_tdata, s_tuser flags the first
//   byte of a packet; a flagged byte always restarts parsing, dropping any
//   packet in progress. bytes seen while idle (payload, junk) are dropped
//   m_ channel: one result item per packet, status plus captured fields
//   a header error (checksum, then version, then protocol) is reported with
//   header byte 19; a good packet is reported with byte 27 (end of udp header)
//   result is registered and appears on m_ in the cycle after the byte that causes it
//   throughput: one byte per cycle while not held by a receiver stall; bytes are
//   held in a 15-deep row of byte cells that shift on every item, the checksum
//   adds one 16-bit word every second header byte
//   receiver stall: the result sits in the output register; input keeps
//   flowing except that a byte at position 19 or 27 waits while the output
//   register is full and m_tready is low
//   reset: synchronous, active low; parser goes idle until the next start
//   byte and the output register empties
module ipv4_udp_header_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic [0:0]   s_tuser,   // [0] packet_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // [1:0] status, [33:2] source_address,
                                    // [65:34] dest_address, [81:66] source_port,
                                    // [97:82] dest_port, [113:98] payload_length,
                                    // [119:114] zero
);
    import iuhp_pkg::*;

    // control state
    logic [4:0]  pos_reg, pos_next;
    logic        version_ok_reg, version_ok_next;
    logic        protocol_ok_reg, protocol_ok_next;
    logic        m_valid_reg, m_valid_next;
    logic [113:0] m_data_reg, m_data_next;

    logic        in_acc;
    logic [4:0]  pos_eff;
    logic        active;
    logic [7:0]  rx_byte;
    logic        err_fire;
    logic        ok_fire;
    status_t     hdr_status;
    csum_ctrl_t  csum_ctrl;
    logic [15:0] sum_next;
    logic [15:0] udp_len;

    // row of byte cells, cell 0 holds the newest byte
    logic [7:0]  chain [CHAIN_DEPTH];

    assign rx_byte = s_tdata;
    assign in_acc  = s_tvalid && s_tready;
    assign pos_eff = s_tuser[0] ? POS_VERSION : pos_reg;
    assign active  = (pos_eff != POS_IDLE);

    // hold off only a byte that may produce a result while the output is blocked
    assign s_tready = !m_valid_reg || m_tready ||
                      !((pos_reg == POS_HDR_LAST) || (pos_reg == POS_UDP_LAST));

    generate
        for (genvar k = 0; k < CHAIN_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                iuhp_byte_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (in_acc),
                    .d_in     (rx_byte),
                    .d_out    (chain[k])
                );
            end else begin : g_body
                iuhp_byte_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (in_acc),
                    .d_in     (chain[k-1]),
                    .d_out    (chain[k])
                );
            end
        end
    endgenerate

    // header words: high byte is the previous byte, held in cell 0
    assign csum_ctrl.clear = in_acc && s_tuser[0];
    assign csum_ctrl.add   = in_acc && active && pos_eff[0] && (pos_eff < HDR_BYTES);

    iuhp_csum u_csum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (csum_ctrl),
        .word     ({chain[0], rx_byte}),
        .sum_next (sum_next)
    );

    // checksum first, then version, then protocol
    always_comb begin
        if (sum_next != SUM_GOOD) begin
            hdr_status = ST_BAD_CSUM;
        end else if (!version_ok_reg) begin
            hdr_status = ST_NOT_IPV4;
        end else if (!protocol_ok_reg) begin
            hdr_status = ST_NOT_UDP;
        end else begin
            hdr_status = ST_OK;
        end
    end

    assign err_fire = in_acc && (pos_eff == POS_HDR_LAST) && (hdr_status != ST_OK);
    assign ok_fire  = in_acc && (pos_eff == POS_UDP_LAST);

    // at byte 27 the cells hold bytes 26 down to 12
    assign udp_len = {chain[2], chain[1]} - UDP_HDR_LEN;

    always_comb begin
        pos_next         = pos_reg;
        version_ok_next  = version_ok_reg;
        protocol_ok_next = protocol_ok_reg;
        if (in_acc) begin
            if (!active) begin
                pos_next = POS_IDLE;
            end else if (err_fire || ok_fire) begin
                pos_next = POS_IDLE;
            end else begin
                pos_next = pos_eff + 5'd1;
            end
            if (active && (pos_eff == POS_VERSION)) begin
                version_ok_next = (rx_byte[7:4] == IPV4_VERSION);
            end
            if (pos_eff == POS_PROTOCOL) begin
                protocol_ok_next = (rx_byte == UDP_PROTOCOL);
            end
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (err_fire) begin
            // at byte 19 the cells hold bytes 18 down to 4
            m_valid_next = 1'b1;
            m_data_next  = {16'd0, 16'd0, 16'd0,
                            chain[2], chain[1], chain[0], rx_byte,
                            chain[6], chain[5], chain[4], chain[3],
                            hdr_status};
        end else if (ok_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {udp_len,
                            chain[4], chain[3],
                            chain[6], chain[5],
                            chain[10], chain[9], chain[8], chain[7],
                            chain[14], chain[13], chain[12], chain[11],
                            ST_OK};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= POS_IDLE;
            version_ok_reg  <= 1'b0;
            protocol_ok_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            version_ok_reg  <= version_ok_next;
            protocol_ok_reg <= protocol_ok_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    // position never leaves the range 0..idle
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_IDLE)
        else $error("byte position out of range");

    // a result always sends the parser idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_fire || ok_fire) |=> (pos_reg == POS_IDLE))
        else $error("parser not idle after result");

    // a result is never produced into a blocked output register
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_fire || ok_fire) |-> (!m_valid_reg || m_tready))
        else $error("result overwrote a pending item");

endmodule
